[rtl/scsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared widths, codes and types of the size-class slot allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  // Geometry
  localparam int NUM_CLASSES  = 64;
  localparam int SLOT_UNIT    = 8;
  localparam int REGION_BYTES = 262144;
  localparam int SIZE_LIMIT   = 512;
  localparam int HEADER_BYTES = 8;

  // Field widths
  localparam int ACTION_W = 1;
  localparam int SIZE_W   = 16;
  localparam int ADDR_W   = 18;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 17;

  // Internal widths
  localparam int PTR_W     = 19;                        // bump pointers, block base
  localparam int SUM_W     = PTR_W + 1;                 // base + block_bytes
  localparam int CLASS_W   = $clog2(NUM_CLASSES);
  localparam int UNIT_W    = $clog2(SLOT_UNIT);
  localparam int SLOT_W    = CLASS_W + 1 + UNIT_W;      // largest slot size
  localparam int LINK_AW   = ADDR_W - UNIT_W;
  localparam int LINK_DEPTH = REGION_BYTES / SLOT_UNIT;
  localparam int REM_CNT_W = $clog2(PTR_W);

  localparam logic [SUM_W-1:0]  REGION_SUM  = SUM_W'(REGION_BYTES);
  localparam logic [SIZE_W-1:0] SIZE_MAX    = SIZE_W'(SIZE_LIMIT);
  localparam logic [PTR_W-1:0]  HEADER_PTR  = PTR_W'(HEADER_BYTES);
  localparam logic [CFG_W-1:0]  BLOCK_RESET = CFG_W'(4096);

  // Request codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_OOM       = 2'd2,
    ST_BAD       = 2'd3
  } status_e;

  // Free list head, also the content of one link entry
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
  } head_t;

  // One row of the per-class table
  typedef struct packed {
    head_t            head;
    logic [PTR_W-1:0] bump_next;
    logic [PTR_W-1:0] bump_limit;
  } class_entry_t;

  // Write request into the per-class table
  typedef struct packed {
    logic               we;
    logic [CLASS_W-1:0] idx;
    class_entry_t       data;
  } class_wr_t;

endpackage
`default_nettype wire

[rtl/size_class_slot_allocator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_slot_allocator_core
// Segregated free-list slot allocator with per-class bump blocks.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single
// result appears on slot_address_o and status_o for exactly one cycle with
// done_o high, and must be captured then, since the block cannot be held
// off. Rejected requests (zero size, too large, bad free address) answer
// in the cycle after acceptance without raising busy. A free and a bump
// allocation end in the evaluation state, a pop from a free list in the pop
// state after it (class table read, then link memory read). An allocation
// that carves a new block runs the alignment remainder through a bit-serial
// unit, one dividend bit per cycle. No clearing pass follows reset: the
// class table carries a valid bit per row. block_bytes_i is written with
// block_bytes_we_i and must only change while the block is idle.
// ----------------------------------------------------------------------------
module size_class_slot_allocator_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          block_bytes_we_i,
  input  wire logic [scsa_pkg::CFG_W-1:0]    block_bytes_i,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [scsa_pkg::ACTION_W-1:0] action_i,
  input  wire logic [scsa_pkg::SIZE_W-1:0]   size_bytes_i,
  input  wire logic [scsa_pkg::ADDR_W-1:0]   free_address_i,
  output logic                               done_o,
  output logic [scsa_pkg::ADDR_W-1:0]        slot_address_o,
  output logic [scsa_pkg::STATUS_W-1:0]      status_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_POP  = 4'b0100,
    S_DIV  = 4'b1000
  } state_e;

  state_e                              state_q, state_d;
  logic [scsa_pkg::CFG_W-1:0]          block_bytes_q;
  logic [scsa_pkg::PTR_W-1:0]          base_q, base_d;
  logic [scsa_pkg::ACTION_W-1:0]       action_q;
  logic [scsa_pkg::CLASS_W-1:0]        class_q;
  logic [scsa_pkg::ADDR_W-1:0]         addr_q;
  logic                                done_q, done_d;
  logic [scsa_pkg::ADDR_W-1:0]         slot_q, slot_d;
  scsa_pkg::status_e                   status_q, status_d;

  logic                                accept;
  logic [scsa_pkg::SIZE_W-1:0]         size_m1;
  logic [scsa_pkg::CLASS_W-1:0]        in_class;
  logic                                in_bad;
  logic                                in_large;

  logic [scsa_pkg::CLASS_W-1:0]        tbl_rd_idx;
  scsa_pkg::class_entry_t              entry;
  scsa_pkg::class_wr_t                 tbl_wr;
  logic                                link_we;
  scsa_pkg::head_t                     link_rd;

  logic [scsa_pkg::SLOT_W-1:0]         slot_size;
  logic [scsa_pkg::PTR_W-1:0]          slot_ptr;
  logic [scsa_pkg::SUM_W-1:0]          carve_sum;
  logic                                carve_over;
  logic [scsa_pkg::PTR_W-1:0]          blk_start;
  logic [scsa_pkg::PTR_W-1:0]          blk_end;
  logic [scsa_pkg::PTR_W-1:0]          new_next;
  logic [scsa_pkg::PTR_W-1:0]          new_limit;
  logic                                rem_start;
  logic                                rem_done;
  logic [scsa_pkg::SLOT_W-1:0]         rem;

  // Decode the incoming request; a size too large wins over a bad free address
  always_comb begin
    accept   = start && (state_q == S_IDLE);
    size_m1  = size_bytes_i - 1'b1;
    in_class = size_m1[scsa_pkg::UNIT_W +: scsa_pkg::CLASS_W];
    in_large = size_bytes_i > scsa_pkg::SIZE_MAX;
    in_bad   = (size_bytes_i == '0) ||
               (!in_large && (action_i == scsa_pkg::ACT_FREE) &&
                ((free_address_i == '0) ||
                 (free_address_i[scsa_pkg::UNIT_W-1:0] != '0)));
  end

  // Slot size and block carving arithmetic
  always_comb begin
    slot_size  = {({1'b0, class_q} + 1'b1), {scsa_pkg::UNIT_W{1'b0}}};
    slot_ptr   = scsa_pkg::PTR_W'(slot_size);
    carve_sum  = {1'b0, base_q} + scsa_pkg::SUM_W'(block_bytes_q);
    carve_over = carve_sum > scsa_pkg::REGION_SUM;
    blk_start  = base_q + scsa_pkg::HEADER_PTR;
    blk_end    = carve_sum[scsa_pkg::PTR_W-1:0] + 1'b1;
    new_next   = (rem == '0) ? blk_start
                             : (blk_start + slot_ptr - scsa_pkg::PTR_W'(rem));
    new_limit  = (blk_end > slot_ptr) ? (blk_end - slot_ptr) : '0;
  end

  assign tbl_rd_idx = (state_q == S_IDLE) ? in_class : class_q;

  // Sequence one request through the table, link memory and remainder unit
  always_comb begin
    state_d      = state_q;
    base_d       = base_q;
    done_d       = 1'b0;
    slot_d       = slot_q;
    status_d     = status_q;
    tbl_wr.we    = 1'b0;
    tbl_wr.idx   = class_q;
    tbl_wr.data  = entry;
    link_we      = 1'b0;
    rem_start    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_bad) begin
            done_d   = 1'b1;
            slot_d   = '0;
            status_d = scsa_pkg::ST_BAD;
          end else if (in_large) begin
            done_d   = 1'b1;
            slot_d   = '0;
            status_d = scsa_pkg::ST_TOO_LARGE;
          end else begin
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (action_q == scsa_pkg::ACT_FREE) begin
          // Push: old head goes to the link of the freed slot
          tbl_wr.we              = 1'b1;
          tbl_wr.data.head.valid = 1'b1;
          tbl_wr.data.head.addr  = addr_q;
          link_we                = 1'b1;
          done_d                 = 1'b1;
          slot_d                 = '0;
          status_d               = scsa_pkg::ST_OK;
          state_d                = S_IDLE;
        end else if (entry.head.valid) begin
          // Pop: link of the head slot is read for the new head
          state_d = S_POP;
        end else if (entry.bump_next < entry.bump_limit) begin
          tbl_wr.we             = 1'b1;
          tbl_wr.data.bump_next = entry.bump_next + slot_ptr;
          done_d                = 1'b1;
          slot_d                = entry.bump_next[scsa_pkg::ADDR_W-1:0];
          status_d              = scsa_pkg::ST_OK;
          state_d               = S_IDLE;
        end else if (carve_over) begin
          done_d   = 1'b1;
          slot_d   = '0;
          status_d = scsa_pkg::ST_OOM;
          state_d  = S_IDLE;
        end else begin
          rem_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_POP: begin
        tbl_wr.we        = 1'b1;
        tbl_wr.data.head = link_rd;
        done_d           = 1'b1;
        slot_d           = entry.head.addr;
        status_d         = scsa_pkg::ST_OK;
        state_d          = S_IDLE;
      end
      S_DIV: begin
        if (rem_done) begin
          // Commit the new block and take its first slot if one fits
          base_d                 = carve_sum[scsa_pkg::PTR_W-1:0];
          tbl_wr.we              = 1'b1;
          tbl_wr.data.bump_limit = new_limit;
          done_d                 = 1'b1;
          state_d                = S_IDLE;
          if (new_next < new_limit) begin
            tbl_wr.data.bump_next = new_next + slot_ptr;
            slot_d                = new_next[scsa_pkg::ADDR_W-1:0];
            status_d              = scsa_pkg::ST_OK;
          end else begin
            tbl_wr.data.bump_next = new_next;
            slot_d                = '0;
            status_d              = scsa_pkg::ST_OOM;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      block_bytes_q <= scsa_pkg::BLOCK_RESET;
      base_q        <= '0;
      done_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q  <= base_d;
      done_q  <= done_d;
      if (block_bytes_we_i) begin
        block_bytes_q <= block_bytes_i;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= action_i;
      class_q  <= in_class;
      addr_q   <= free_address_i;
    end
    slot_q   <= slot_d;
    status_q <= status_d;
  end

  scsa_class_table u_class_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (tbl_rd_idx),
    .wr_i       (tbl_wr),
    .rd_entry_o (entry)
  );

  scsa_link_mem u_link_mem (
    .clk_i     (clk_i),
    .we_i      (link_we),
    .wr_idx_i  (addr_q[scsa_pkg::ADDR_W-1:scsa_pkg::UNIT_W]),
    .wr_data_i (entry.head),
    .rd_idx_i  (entry.head.addr[scsa_pkg::ADDR_W-1:scsa_pkg::UNIT_W]),
    .rd_data_o (link_rd)
  );

  scsa_rem_unit u_rem_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (blk_start),
    .divisor_i  (slot_size),
    .done_o     (rem_done),
    .rem_o      (rem)
  );

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign slot_address_o = slot_q;
  assign status_o       = status_q;

endmodule
`default_nettype wire

[rtl/scsa_rem_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_rem_unit
// Restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module scsa_rem_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [scsa_pkg::PTR_W-1:0]   dividend_i,
  input  wire logic [scsa_pkg::SLOT_W-1:0]  divisor_i,
  output logic                              done_o,
  output logic [scsa_pkg::SLOT_W-1:0]       rem_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [scsa_pkg::REM_CNT_W-1:0]    cnt_q;
  logic [scsa_pkg::PTR_W-1:0]        num_q;
  logic [scsa_pkg::SLOT_W-1:0]       den_q;
  logic [scsa_pkg::SLOT_W-1:0]       rem_q;
  logic [scsa_pkg::SLOT_W:0]         trial;
  logic [scsa_pkg::SLOT_W:0]         rem_step;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial    = {rem_q, num_q[scsa_pkg::PTR_W-1]};
    rem_step = (trial >= {1'b0, den_q}) ? (trial - {1'b0, den_q}) : trial;
  end

  // Control: run for one step per dividend bit, pulse done at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == scsa_pkg::REM_CNT_W'(scsa_pkg::PTR_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[scsa_pkg::PTR_W-2:0], 1'b0};
      rem_q <= rem_step[scsa_pkg::SLOT_W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

[rtl/scsa_class_table.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_class_table
// Per-class free list heads and bump state in one synchronous memory.
// Rows never written read as all zero through a valid bit per row.
// ----------------------------------------------------------------------------
module scsa_class_table (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [scsa_pkg::CLASS_W-1:0]  rd_idx_i,
  input  wire scsa_pkg::class_wr_t           wr_i,
  output scsa_pkg::class_entry_t             rd_entry_o
);

  scsa_pkg::class_entry_t             mem [scsa_pkg::NUM_CLASSES];
  logic [scsa_pkg::NUM_CLASSES-1:0]   valid_q;
  scsa_pkg::class_entry_t             rd_data_q;
  logic                               rd_valid_q;

  // Mark rows as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= valid_q[rd_idx_i];
      if (wr_i.we) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
    end
  end

  // Memory array with registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.idx] <= wr_i.data;
    end
    rd_data_q <= mem[rd_idx_i];
  end

  assign rd_entry_o = rd_valid_q ? rd_data_q : '0;

endmodule
`default_nettype wire

[rtl/scsa_link_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_link_mem
// Next links of free slots, one entry per slot unit of the region.
// ----------------------------------------------------------------------------
module scsa_link_mem (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [scsa_pkg::LINK_AW-1:0]  wr_idx_i,
  input  wire scsa_pkg::head_t               wr_data_i,
  input  wire logic [scsa_pkg::LINK_AW-1:0]  rd_idx_i,
  output scsa_pkg::head_t                    rd_data_o
);

  scsa_pkg::head_t mem [scsa_pkg::LINK_DEPTH];
  scsa_pkg::head_t rd_data_q;

  // Write on push, registered read on pop
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_idx_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire
